// ===== design/tccw_pkg.sv =====
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants for the text console cursor writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

   // Character codes with special meaning.
   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   // Attribute byte after reset.
   localparam logic [7:0] RESET_COLOUR = 8'h0F;

   // Fixed widths of the result fields.
   localparam int INDEX_W = 11;
   localparam int WORD_W  = 16;
   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;

   // One result of a request.
   typedef struct packed {
      logic               cell_written;
      logic [INDEX_W-1:0] cell_index;
      logic [WORD_W-1:0]  cell_word;
      logic               screen_cleared;
      logic [ROW_W-1:0]   cursor_row;
      logic [COL_W-1:0]   cursor_col;
   } tccw_result_type;

   // Blank cell in the given colour.
   function automatic logic [WORD_W-1:0] blank_word(input logic [7:0] colour);
      return {colour, CH_SPACE};
   endfunction

endpackage

// ===== design/tccw_screen_ram.sv =====
// ----------------------------------------------------------------------------
// tccw_screen_ram
// Screen cell memory with one write port and a clearing sweep that blanks
// every cell, one per cycle, after reset and after each screen clear.
// ----------------------------------------------------------------------------
module tccw_screen_ram #(
   parameter int CELLS = 2000
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [$clog2(CELLS)-1:0]   wr_addr,
   input  logic [15:0]                wr_data,
   input  logic                       clear_start,
   input  logic [7:0]                 clear_colour,
   output logic                       busy
);
   import tccw_pkg::*;

   localparam int IW = $clog2(CELLS);

   logic [15:0]   mem [CELLS];
   logic          sweep_ff, sweep_in;
   logic [IW-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic [15:0]   sweep_word_ff, sweep_word_in;
   logic          mem_we;
   logic [IW-1:0] mem_addr;
   logic [15:0]   mem_data;

   // Sweep control: start on a clear, stop after the last cell.
   always_comb begin
      sweep_in      = sweep_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      sweep_word_in = sweep_word_ff;
      if (clear_start) begin
         sweep_in      = 1'b1;
         sweep_cnt_in  = '0;
         sweep_word_in = blank_word(clear_colour);
      end else if (sweep_ff) begin
         if (sweep_cnt_ff == IW'(CELLS - 1)) begin
            sweep_in = 1'b0;
         end
         sweep_cnt_in = sweep_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= 1'b1;
         sweep_cnt_ff  <= '0;
         sweep_word_ff <= blank_word(RESET_COLOUR);
      end else begin
         sweep_ff      <= sweep_in;
         sweep_cnt_ff  <= sweep_cnt_in;
         sweep_word_ff <= sweep_word_in;
      end
   end

   // The sweep owns the write port while it runs.
   always_comb begin
      mem_we   = sweep_ff | wr_en;
      mem_addr = sweep_ff ? sweep_cnt_ff : wr_addr;
      mem_data = sweep_ff ? sweep_word_ff : wr_data;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_data;
      end
   end

   assign busy = sweep_ff;

   // A clear always starts a sweep.
   a_clear_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      clear_start |=> busy)
      else $error("clear did not start the sweep");

   // No request write arrives while the sweep runs.
   a_no_write_in_sweep: assert property (@(posedge clock) disable iff (reset)
      !(sweep_ff && wr_en))
      else $error("request write during clearing sweep");

   // The sweep counter stays inside the store.
   a_sweep_in_range: assert property (@(posedge clock) disable iff (reset)
      sweep_ff |-> (sweep_cnt_ff <= IW'(CELLS - 1)))
      else $error("sweep counter out of range");

endmodule

// ===== design/tccw_cursor.sv =====
// ----------------------------------------------------------------------------
// tccw_cursor
// Cursor registers and character decode. Builds the result of a request and
// the cell write that goes to the screen memory.
// ----------------------------------------------------------------------------
module tccw_cursor #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [7:0]                          char_code,
   input  logic [7:0]                          colour,
   output tccw_pkg::tccw_result_type           result,
   output logic                                wr_en,
   output logic [$clog2(ROWS*COLUMNS)-1:0]     wr_addr,
   output logic [15:0]                         wr_data
);
   import tccw_pkg::*;

   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(COLUMNS);
   localparam int IW = $clog2(ROWS * COLUMNS);

   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;

   // Decode the character and work out the new cursor and the cell.
   always_comb begin
      logic [RW-1:0] idx_row;
      logic [CW-1:0] idx_col;
      logic [IW-1:0] idx;
      logic [15:0]   word;
      logic          written;
      logic          cleared;
      logic          to_next_row;

      row_in      = row_ff;
      col_in      = col_ff;
      idx_row     = row_ff;
      idx_col     = col_ff;
      word        = {colour, char_code};
      written     = 1'b1;
      cleared     = 1'b0;
      to_next_row = 1'b0;

      case (char_code)
         CH_BACKSPACE: begin
            if (col_ff != '0) begin
               col_in = col_ff - 1'b1;
            end else if (row_ff != '0) begin
               row_in = row_ff - 1'b1;
               col_in = CW'(COLUMNS - 1);
            end
            idx_row = row_in;
            idx_col = col_in;
            word    = blank_word(colour);
         end
         CH_NEWLINE: begin
            written     = 1'b0;
            word        = '0;
            to_next_row = 1'b1;
         end
         default: begin
            if (col_ff == CW'(COLUMNS - 1)) begin
               to_next_row = 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
      endcase

      // Row advance, with a screen clear past the last row.
      if (to_next_row) begin
         col_in = '0;
         if (row_ff == RW'(ROWS - 1)) begin
            row_in  = '0;
            cleared = 1'b1;
         end else begin
            row_in = row_ff + 1'b1;
         end
      end

      idx = IW'(idx_row) * IW'(COLUMNS) + IW'(idx_col);
      if (!written) begin
         idx = '0;
      end

      result.cell_written   = written;
      result.cell_index     = INDEX_W'(idx);
      result.cell_word      = word;
      result.screen_cleared = cleared;
      result.cursor_row     = ROW_W'(row_in);
      result.cursor_col     = COL_W'(col_in);

      wr_en   = accept & written;
      wr_addr = idx;
      wr_data = word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // The cursor stays on the screen.
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= RW'(ROWS - 1))
      else $error("cursor row out of range");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= CW'(COLUMNS - 1))
      else $error("cursor column out of range");

   // A clear leaves the cursor at home.
   a_clear_homes: assert property (@(posedge clock) disable iff (reset)
      (accept && result.screen_cleared) |=> (row_ff == '0 && col_ff == '0))
      else $error("cursor not homed after clear");

endmodule

// ===== design/text_console_cursor_writer_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_writer_unit
// Text console writer: prints character requests into a screen memory and
// tracks the cursor, with newline, backspace, wrap and clear on overflow.
//
//   Channel  Direction  Handshake                Payload
//   req_     in         req_valid / req_stall    char_code
//   rsp_     out        rsp_valid / rsp_stall    cell and cursor fields
//   csr_     in         csr_write_enable         text colour (8 bits)
//
// A request's response appears in the output register in the cycle after
// the request is taken; one request per cycle is sustained while req_stall
// stays low. A screen clear blanks the memory one cell per cycle, with
// req_stall high throughout. The same sweep runs after reset.
// req_stall is also high while a response waits under rsp_stall.
// ----------------------------------------------------------------------------
module text_console_cursor_writer_unit #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_cell_written,
   output logic [10:0] rsp_cell_index,
   output logic [15:0] rsp_cell_word,
   output logic        rsp_screen_cleared,
   output logic [4:0]  rsp_cursor_row_out,
   output logic [6:0]  rsp_cursor_col_out,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);
   import tccw_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int IW    = $clog2(CELLS);

   logic [7:0]       colour_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   tccw_result_type  rsp_ff;
   tccw_result_type  result;
   logic             accept;
   logic             busy;
   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   logic [15:0]      wr_data;

   // Colour register.
   always_ff @(posedge clock) begin
      if (reset) begin
         colour_ff <= RESET_COLOUR;
      end else if (csr_write_enable) begin
         colour_ff <= csr_write_data;
      end
   end

   // Request handshake.
   assign req_stall = busy | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;

   tccw_cursor #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_cursor (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_code (req_char_code),
      .colour    (colour_ff),
      .result    (result),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   tccw_screen_ram #(
      .CELLS (CELLS)
   ) u_screen_ram (
      .clock        (clock),
      .reset        (reset),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .clear_start  (accept & result.screen_cleared),
      .clear_colour (colour_ff),
      .busy         (busy)
   );

   // Response register.
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cell_written   = rsp_ff.cell_written;
   assign rsp_cell_index     = rsp_ff.cell_index;
   assign rsp_cell_word      = rsp_ff.cell_word;
   assign rsp_screen_cleared = rsp_ff.screen_cleared;
   assign rsp_cursor_row_out = rsp_ff.cursor_row;
   assign rsp_cursor_col_out = rsp_ff.cursor_col;

   // Every accepted request shows up as a response.
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   // A waiting response is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !accept)
      else $error("pending response overwritten");

   // Nothing is accepted while the screen is being cleared.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !accept)
      else $error("request accepted during clear");

endmodule

// ===== tb/text_console_cursor_writer_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_writer_unit_checker
// Watches the request, response and colour ports of the text console writer.
// It keeps its own cursor and colour, works out the screen update that every
// accepted request must produce, and compares each accepted response with the
// oldest update still waiting. Mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module text_console_cursor_writer_unit_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_cell_written,
   input  logic [10:0] rsp_cell_index,
   input  logic [15:0] rsp_cell_word,
   input  logic        rsp_screen_cleared,
   input  logic [4:0]  rsp_cursor_row_out,
   input  logic [6:0]  rsp_cursor_col_out,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   output int          error_count,
   output int          pending_count
);
   import tccw_pkg::*;

   // Screen updates predicted for requests whose response has not come yet.
   tccw_result_type pending_screen_updates[$];

   // Shadow of the cursor and of the colour register.
   logic [7:0] text_colour;
   int         cursor_row;
   int         cursor_col;

   initial begin
      error_count   = 0;
      pending_count = 0;
      text_colour   = RESET_COLOUR;
      cursor_row    = 0;
      cursor_col    = 0;
   end

   // Moves the cursor to the start of the next row and reports whether
   // running off the bottom blanked the screen.
   function automatic logic move_to_next_row();
      cursor_col = 0;
      cursor_row = cursor_row + 1;
      if (cursor_row >= ROWS) begin
         cursor_row = 0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Applies one character to the shadow cursor and returns the update that
   // the block must report for it.
   task automatic apply_char(input logic [7:0] char_code, output tccw_result_type upd);
      upd = '0;
      if (char_code == CH_BACKSPACE) begin
         // Step back, crossing to the end of the row above; at home stay put.
         if (cursor_col > 0) begin
            cursor_col = cursor_col - 1;
         end else if (cursor_row > 0) begin
            cursor_row = cursor_row - 1;
            cursor_col = COLUMNS - 1;
         end
         upd.cell_written = 1'b1;
         upd.cell_index   = INDEX_W'(cursor_row * COLUMNS + cursor_col);
         upd.cell_word    = {text_colour, CH_SPACE};
      end else if (char_code == CH_NEWLINE) begin
         upd.screen_cleared = move_to_next_row();
      end else begin
         // Printed character: write at the cursor, then advance and wrap.
         upd.cell_written = 1'b1;
         upd.cell_index   = INDEX_W'(cursor_row * COLUMNS + cursor_col);
         upd.cell_word    = {text_colour, char_code};
         cursor_col       = cursor_col + 1;
         if (cursor_col >= COLUMNS) begin
            upd.screen_cleared = move_to_next_row();
         end
      end
      upd.cursor_row = ROW_W'(cursor_row);
      upd.cursor_col = COL_W'(cursor_col);
   endtask

   // Counts a field mismatch; only the first ones are shown.
   task automatic check_field(input string field_name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         error_count = error_count + 1;
         if (error_count <= 10) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $realtime, field_name, want, got);
         end
      end
   endtask

   // All port activity is sampled at the rising edge.
   always @(posedge clock) begin
      tccw_result_type want;
      tccw_result_type upd;
      if (reset) begin
         text_colour = RESET_COLOUR;
         cursor_row  = 0;
         cursor_col  = 0;
         pending_screen_updates.delete();
      end else begin
         if (csr_write_enable) begin
            text_colour = csr_write_data;
         end

         // Response side: compare against the oldest prediction.
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (pending_screen_updates.size() == 0) begin
               error_count = error_count + 1;
               if (error_count <= 10) begin
                  $display("%0t: response with no request outstanding", $realtime);
               end
            end else begin
               want = pending_screen_updates.pop_front();
               check_field("cell_written", 16'(want.cell_written),
                           16'(rsp_cell_written));
               check_field("cell_index", 16'(want.cell_index), 16'(rsp_cell_index));
               check_field("cell_word", want.cell_word, rsp_cell_word);
               check_field("screen_cleared", 16'(want.screen_cleared),
                           16'(rsp_screen_cleared));
               check_field("cursor_row", 16'(want.cursor_row), 16'(rsp_cursor_row_out));
               check_field("cursor_col", 16'(want.cursor_col), 16'(rsp_cursor_col_out));
            end
         end

         // Request side: predict the update for every accepted character.
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            apply_char(req_char_code, upd);
            pending_screen_updates.push_back(upd);
         end
      end
      pending_count = pending_screen_updates.size();
   end

endmodule

// ===== tb/text_console_cursor_writer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_writer_unit_tb
// Drives character requests into the text console writer under random input
// gaps and output stalls, with several text colours, and lets the checker
// compare every response. A short directed run covers the byte extremes,
// newline, backspace at home and across rows, and wrap at the row end; the
// random run mixes lines, long runs, newline/backspace bursts and raw bytes.
// ----------------------------------------------------------------------------
module text_console_cursor_writer_unit_tb;
   import tccw_pkg::*;

   localparam int SCREEN_COLUMNS = 80;
   localparam int SCREEN_ROWS    = 25;
   localparam int PHASE_REQUESTS = 135;
   localparam int PHASE_COUNT    = 5;
   localparam int LONG_HOLD      = 300;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_char_code;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_cell_written;
   logic [10:0] rsp_cell_index;
   logic [15:0] rsp_cell_word;
   logic        rsp_screen_cleared;
   logic [4:0]  rsp_cursor_row_out;
   logic [6:0]  rsp_cursor_col_out;
   logic        csr_write_enable;
   logic [7:0]  csr_write_data;

   int          error_count;
   int          pending_count;

   // Stimulus controls shared between the sender and the receiver.
   logic        idle_enable = 1'b1;
   logic        long_hold_req = 1'b0;
   logic        long_hold_taken;
   logic        sender_gaps;
   logic [4:0]  last_row = '0;
   logic [7:0]  directed_chars [0:16];

   // Clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   text_console_cursor_writer_unit #(
      .COLUMNS (SCREEN_COLUMNS),
      .ROWS    (SCREEN_ROWS)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_code      (req_char_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_cell_written   (rsp_cell_written),
      .rsp_cell_index     (rsp_cell_index),
      .rsp_cell_word      (rsp_cell_word),
      .rsp_screen_cleared (rsp_screen_cleared),
      .rsp_cursor_row_out (rsp_cursor_row_out),
      .rsp_cursor_col_out (rsp_cursor_col_out),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   text_console_cursor_writer_unit_checker #(
      .COLUMNS (SCREEN_COLUMNS),
      .ROWS    (SCREEN_ROWS)
   ) checker_inst (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_code      (req_char_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_cell_written   (rsp_cell_written),
      .rsp_cell_index     (rsp_cell_index),
      .rsp_cell_word      (rsp_cell_word),
      .rsp_screen_cleared (rsp_screen_cleared),
      .rsp_cursor_row_out (rsp_cursor_row_out),
      .rsp_cursor_col_out (rsp_cursor_col_out),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .error_count        (error_count),
      .pending_count      (pending_count)
   );

   // Rough cursor row seen on the output, used to steer long runs of text
   // onto the last row so that a printed character triggers the clear.
   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         last_row <= rsp_cursor_row_out;
      end
   end

   // Offers one character and returns at the falling edge after it is taken.
   task automatic send_char(input logic [7:0] char_code);
      if (idle_enable && sender_gaps && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= char_code;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   // Any byte except the two control codes.
   task automatic send_printable();
      logic [7:0] char_code;
      do char_code = 8'($urandom_range(0, 255));
      while (char_code == CH_BACKSPACE || char_code == CH_NEWLINE);
      send_char(char_code);
   endtask

   // One random piece of text; count tells how many requests it took.
   task automatic send_segment(output int count);
      int pick;
      int len;
      sender_gaps = ($urandom_range(0, 3) != 0);
      pick        = $urandom_range(0, 99);
      if (last_row == SCREEN_ROWS - 1 && $urandom_range(0, 1) == 1) begin
         pick = 40;
      end
      if (pick < 35) begin
         // A short line ended by newline.
         len = $urandom_range(0, 30);
         repeat (len) send_printable();
         send_char(CH_NEWLINE);
         count = len + 1;
      end else if (pick < 55) begin
         // A run long enough to wrap at least one row.
         len = $urandom_range(SCREEN_COLUMNS, SCREEN_COLUMNS + 20);
         repeat (len) send_printable();
         count = len;
      end else if (pick < 75) begin
         // Blank lines, often enough to run off the bottom.
         len = $urandom_range(1, SCREEN_ROWS);
         repeat (len) send_char(CH_NEWLINE);
         count = len;
      end else if (pick < 88) begin
         // Backspaces, sometimes enough to cross rows or reach home.
         len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 8);
         repeat (len) send_char(CH_BACKSPACE);
         count = len;
      end else begin
         // Raw bytes of any value.
         len = $urandom_range(1, 8);
         repeat (len) send_char(8'($urandom_range(0, 255)));
         count = len;
      end
   endtask

   // Waits until every response is back and no clear sweep is running.
   task automatic wait_idle();
      while (pending_count != 0 || req_stall !== 1'b0) @(negedge clock);
   endtask

   task automatic write_colour(input logic [7:0] colour);
      csr_write_enable <= 1'b1;
      csr_write_data   <= colour;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Receiver: random stall bursts, one long hold-off, none at the end.
   initial begin
      int   hold_len;
      logic hold_value;
      rsp_stall       = 1'b0;
      long_hold_taken = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold_req && !long_hold_taken) begin
            long_hold_taken = 1'b1;
            hold_value      = 1'b1;
            hold_len        = LONG_HOLD;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            hold_value = 1'b1;
            hold_len   = $urandom_range(1, 17);
         end else begin
            hold_value = 1'b0;
            hold_len   = $urandom_range(1, 30);
         end
         rsp_stall <= hold_value;
         repeat (hold_len) @(negedge clock);
      end
   end

   // Stimulus and verdict.
   initial begin
      int         sent;
      int         count;
      logic [7:0] colour;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_char_code    = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      sender_gaps      = 1'b1;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Directed text in the reset colour: backspace at home, byte extremes
      // and single bits, neighbors of the control codes, backspace across a
      // row, and a character that wraps at the end of a row.
      directed_chars = '{CH_BACKSPACE, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA,
                         CH_SPACE, 8'h09, 8'h0B, CH_NEWLINE, CH_BACKSPACE, 8'h41,
                         CH_BACKSPACE, CH_BACKSPACE, CH_NEWLINE, 8'h01};
      wait_idle();
      foreach (directed_chars[i]) send_char(directed_chars[i]);
      req_valid <= 1'b0;

      // Random text under several colours; the last phase runs without gaps.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_idle();
         case (phase)
            0:       colour = 8'h00;
            1:       colour = 8'hFF;
            4:       colour = RESET_COLOUR;
            default: colour = 8'($urandom_range(0, 255));
         endcase
         write_colour(colour);
         if (phase == PHASE_COUNT - 1) begin
            idle_enable <= 1'b0;
         end
         if (phase == 1) begin
            long_hold_req <= 1'b1;
         end
         sent = 0;
         while (sent < PHASE_REQUESTS) begin
            send_segment(count);
            sent = sent + count;
         end
         req_valid <= 1'b0;
      end

      wait_idle();
      repeat (40) @(negedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("text_console_cursor_writer_unit regression: pass");
      end else begin
         $display("text_console_cursor_writer_unit regression: fail");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5_000_000;
      $display("text_console_cursor_writer_unit regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/tccw_pkg.sv
design/tccw_screen_ram.sv
design/tccw_cursor.sv
design/text_console_cursor_writer_unit.sv
tb/text_console_cursor_writer_unit_checker.sv
tb/text_console_cursor_writer_unit_tb.sv
